### hw/rtl/mcdt_pkg.sv
// Shared types, codes and defaults for the multi-channel down timer.
// No dependencies; imported by every module of the timer.
`default_nettype none

package mcdt_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_CHANNELS = 4;
  localparam int DEF_COUNT_BITS   = 31;

  localparam int DATA_W    = 32;
  localparam int CHAN_W    = 2;
  localparam int REG_IDX_W = 2;
  localparam int ACTION_W  = 2;
  localparam int MASK_W    = 4;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CONTROL  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_STATUS   = 2'd3;

  // Bit positions
  localparam int LOAD_BIT        = 31;
  localparam int CTL_INTEN_BIT   = 0;
  localparam int CTL_ONESHOT_BIT = 1;
  localparam int STS_PENDING_BIT = 0;
  localparam int STS_RUNNING_BIT = 1;

  // Command from the execute stage to one channel
  typedef struct packed {
    logic                 tick;
    logic                 wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]    data;
  } chan_cmd_t;

  // Flag bits of one channel
  typedef struct packed {
    logic pending;
    logic enable;
    logic one_shot;
    logic running;
  } chan_flags_t;

endpackage

`default_nettype wire

### hw/rtl/multi_channel_down_timer_unit.sv
// Each result passes through the input register, then the result register.
// Throughput: one item per cycle while out_ready holds high; one more item is held in the input
// register while a result waits for out_ready, after which in_ready drops.
// Rate is set by the single execute stage, which applies a tick to every channel in the same cycle.
// Reset (rst_n low, synchronous): all channels stopped, intervals, counts and flags cleared,
// both pipeline stages empty. Depends on mcdt_pkg and mcdt_channel.
`default_nettype none

module multi_channel_down_timer_unit
  import mcdt_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ACTION_W-1:0]  in_action,
  input  wire logic [CHAN_W-1:0]    in_channel,
  input  wire logic [REG_IDX_W-1:0] in_register_index,
  input  wire logic [DATA_W-1:0]    in_write_data,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [DATA_W-1:0]    out_read_data,
  output logic                      out_irq,
  output logic      [MASK_W-1:0]    out_pending_mask
);

  // ---------------------------------------------------------------------------
  // Input register stage. Holds one item until the execute step can run, i.e.
  // until the result register is empty or being drained in this cycle.
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic [ACTION_W-1:0]  s1_action_r;
  logic [CHAN_W-1:0]    s1_chan_r;
  logic [REG_IDX_W-1:0] s1_reg_r;
  logic [DATA_W-1:0]    s1_data_r;
  logic                 out_valid_r;
  logic                 s1_go;
  logic                 in_xfer;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action_r <= in_action;
      s1_chan_r   <= in_channel;
      s1_reg_r    <= in_register_index;
      s1_data_r   <= in_write_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: a tick goes to every channel, a write only to the addressed one.
  // Channel numbers at or above NUM_CHANNELS match nothing, so writes drop
  // and reads give zero.
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] cnt_w    [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] reload_w [NUM_CHANNELS];
  chan_flags_t           flags_w  [NUM_CHANNELS];
  chan_flags_t           fnxt_w   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] hit;
  logic [NUM_CHANNELS-1:0] pend_nxt;

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    chan_cmd_t cmd;

    assign hit[c] = ({{(DATA_W-CHAN_W){1'b0}}, s1_chan_r} == DATA_W'(c));

    always_comb begin
      cmd.tick    = s1_go && (s1_action_r == ACT_TICK);
      cmd.wr      = s1_go && (s1_action_r == ACT_WRITE) && hit[c];
      cmd.reg_idx = s1_reg_r;
      cmd.data    = s1_data_r;
    end

    mcdt_channel #(
      .COUNT_BITS(COUNT_BITS)
    ) u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .count    (cnt_w[c]),
      .reload   (reload_w[c]),
      .flags    (flags_w[c]),
      .flags_nxt(fnxt_w[c])
    );

    assign pend_nxt[c] = fnxt_w[c].pending;
  end

  // Read mux works on the pre-step state; a read never changes state anyway.
  logic [DATA_W-1:0] rd_data;
  logic              irq_nxt;
  logic [MASK_W-1:0] mask_nxt;

  always_comb begin
    rd_data = '0;
    irq_nxt = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if ((s1_action_r == ACT_READ) && hit[c]) begin
        unique case (s1_reg_r)
          REG_INTERVAL: rd_data = {{(DATA_W-COUNT_BITS){1'b0}}, reload_w[c]};
          REG_COUNT:    rd_data = {{(DATA_W-COUNT_BITS){1'b0}}, cnt_w[c]};
          REG_CONTROL: begin
            rd_data[CTL_INTEN_BIT]   = flags_w[c].enable;
            rd_data[CTL_ONESHOT_BIT] = flags_w[c].one_shot;
          end
          REG_STATUS: begin
            rd_data[STS_PENDING_BIT] = flags_w[c].pending;
            rd_data[STS_RUNNING_BIT] = flags_w[c].running;
          end
          default: rd_data = '0;
        endcase
      end
      // irq and mask reflect the state after this item
      if (fnxt_w[c].pending && fnxt_w[c].enable) begin
        irq_nxt = 1'b1;
      end
    end
  end

  // only the low four channels are visible in the mask
  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < NUM_CHANNELS) begin : g_on
      assign mask_nxt[m] = pend_nxt[m];
    end else begin : g_off
      assign mask_nxt[m] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] rd_data_r;
  logic              irq_r;
  logic [MASK_W-1:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      rd_data_r <= rd_data;
      irq_r     <= irq_nxt;
      mask_r    <= mask_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = rd_data_r;
  assign out_irq          = irq_r;
  assign out_pending_mask = mask_r;

endmodule

`default_nettype wire

### hw/rtl/mcdt_channel.sv
// One timer channel: interval, count and flag registers with tick/write update.
// Depends on mcdt_pkg.
`default_nettype none

module mcdt_channel
  import mcdt_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire chan_cmd_t             cmd,
  output logic      [COUNT_BITS-1:0] count,
  output logic      [COUNT_BITS-1:0] reload,
  output chan_flags_t                flags,
  output chan_flags_t                flags_nxt
);

  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  chan_flags_t           flags_r;
  chan_flags_t           flg_nxt;
  logic [COUNT_BITS-1:0] wr_val;

  assign wr_val = cmd.data[COUNT_BITS-1:0];

  always_comb begin
    reload_nxt = reload_r;
    count_nxt  = count_r;
    flg_nxt    = flags_r;
    if (cmd.tick && flags_r.running) begin
      if (count_r > COUNT_BITS'(1)) begin
        count_nxt = count_r - COUNT_BITS'(1);
      end else begin
        flg_nxt.pending = 1'b1;
        if (flags_r.one_shot || (reload_r == '0)) begin
          count_nxt       = '0;
          flg_nxt.running = 1'b0;
        end else begin
          count_nxt = reload_r;
        end
      end
    end else if (cmd.wr) begin
      unique case (cmd.reg_idx)
        REG_INTERVAL: begin
          reload_nxt = wr_val;
          if (cmd.data[LOAD_BIT]) begin
            count_nxt       = wr_val;
            flg_nxt.running = (wr_val != '0);
          end
        end
        REG_CONTROL: begin
          flg_nxt.enable   = cmd.data[CTL_INTEN_BIT];
          flg_nxt.one_shot = cmd.data[CTL_ONESHOT_BIT];
        end
        REG_STATUS: begin
          if (cmd.data[STS_PENDING_BIT]) begin
            flg_nxt.pending = 1'b0;
          end
        end
        default: begin
          // count register is read only
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= '0;
      count_r  <= '0;
      flags_r  <= '0;
    end else begin
      reload_r <= reload_nxt;
      count_r  <= count_nxt;
      flags_r  <= flg_nxt;
    end
  end

  assign count     = count_r;
  assign reload    = reload_r;
  assign flags     = flags_r;
  assign flags_nxt = flg_nxt;

endmodule

`default_nettype wire

### hw/rtl/mcdt_checker.sv
// Port-level checks for multi_channel_down_timer_unit, bound to the top level.
// Depends on mcdt_pkg.
`default_nettype none

module mcdt_checker
  import mcdt_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [DATA_W-1:0]    out_read_data,
  input wire logic                 out_irq,
  input wire logic [MASK_W-1:0]    out_pending_mask
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_irq) && $stable(out_pending_mask))
    else $error("result changed while stalled");

  // nothing left in the result register after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // with the result register empty the pipe always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // unless there are more channels than mask bits, every interrupt comes from a visible pending channel
  a_irq_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq |-> (NUM_CHANNELS > MASK_W) || (out_pending_mask != '0))
    else $error("irq without a pending channel");

endmodule

bind multi_channel_down_timer_unit mcdt_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_mcdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_read_data   (out_read_data),
  .out_irq         (out_irq),
  .out_pending_mask(out_pending_mask)
);

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the multi-channel down timer unit.
// Drives ticks and register accesses, predicts each result in-house and checks it on transfer.
// Depends on mcdt_pkg and the timer RTL.

module testbench
  import mcdt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int NUM_CH        = DEF_NUM_CHANNELS;
  localparam int CNT_W         = DEF_COUNT_BITS;
  localparam int RESET_CYCLES  = 11;
  localparam int TOTAL_ITEMS   = 1100;
  localparam int QUIET_TAIL    = 120;   // last transfers run with no idling at all
  localparam int DRAIN_CYCLES  = 8;     // slack for the last result to drain
  localparam int TIMEOUT_NS    = 2_000_000;

  // Action 3 has no name in the package: the block treats it as a no-op
  localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CHAN_W-1:0]    channel;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]    data;
  } timer_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic [MASK_W-1:0] pending;
  } timer_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n = 1'b0;

  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  in_action         = '0;
  logic [CHAN_W-1:0]    in_channel        = '0;
  logic [REG_IDX_W-1:0] in_register_index = '0;
  logic [DATA_W-1:0]    in_write_data     = '0;

  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  logic [DATA_W-1:0]    out_read_data;
  logic                 out_irq;
  logic [MASK_W-1:0]    out_pending_mask;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  multi_channel_down_timer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_channel       (in_channel),
    .in_register_index(in_register_index),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_irq          (out_irq),
    .out_pending_mask (out_pending_mask)
  );

  // ---------------------------------------------------------------------------
  // Timer prediction: own copy of every channel's state, reset to zero
  // ---------------------------------------------------------------------------
  bit [CNT_W-1:0] tmr_reload  [NUM_CH];
  bit [CNT_W-1:0] tmr_count   [NUM_CH];
  bit             tmr_run     [NUM_CH];
  bit             tmr_pend    [NUM_CH];
  bit             tmr_inten   [NUM_CH];
  bit             tmr_oneshot [NUM_CH];

  timer_op_t     op_backlog[$];     // items still to be offered to the DUT
  timer_result_t due_results[$];    // predicted results, oldest first
  int            error_count = 0;

  task automatic apply_timer_op(input timer_op_t op, output timer_result_t res);
    logic [DATA_W-1:0] rd;
    int c;
    rd = '0;
    c  = int'(op.channel);
    case (op.action)
      ACT_TICK: begin
        for (int k = 0; k < NUM_CH; k++) begin
          if (tmr_run[k]) begin
            if (tmr_count[k] > 1) begin
              tmr_count[k] = tmr_count[k] - 1'b1;
            end else begin
              // expiry: flag it, then reload or stop (one-shot, or nothing to reload)
              tmr_pend[k] = 1'b1;
              if (tmr_oneshot[k] || tmr_reload[k] == '0) begin
                tmr_count[k] = '0;
                tmr_run[k]   = 1'b0;
              end else begin
                tmr_count[k] = tmr_reload[k];
              end
            end
          end
        end
      end
      ACT_WRITE: begin
        if (c < NUM_CH) begin
          case (op.reg_idx)
            REG_INTERVAL: begin
              tmr_reload[c] = op.data[CNT_W-1:0];
              if (op.data[LOAD_BIT]) begin
                tmr_count[c] = tmr_reload[c];
                tmr_run[c]   = (tmr_reload[c] != '0);
              end
            end
            REG_CONTROL: begin
              tmr_inten[c]   = op.data[CTL_INTEN_BIT];
              tmr_oneshot[c] = op.data[CTL_ONESHOT_BIT];
            end
            REG_STATUS: begin
              if (op.data[STS_PENDING_BIT]) tmr_pend[c] = 1'b0;
            end
            default: ;  // count register is read only
          endcase
        end
      end
      ACT_READ: begin
        if (c < NUM_CH) begin
          case (op.reg_idx)
            REG_INTERVAL: rd = DATA_W'(tmr_reload[c]);
            REG_COUNT:    rd = DATA_W'(tmr_count[c]);
            REG_CONTROL: begin
              rd[CTL_INTEN_BIT]   = tmr_inten[c];
              rd[CTL_ONESHOT_BIT] = tmr_oneshot[c];
            end
            default: begin
              rd[STS_PENDING_BIT] = tmr_pend[c];
              rd[STS_RUNNING_BIT] = tmr_run[c];
            end
          endcase
        end
      end
      default: ;
    endcase

    res.read_data = rd;
    res.irq       = 1'b0;
    res.pending   = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      if (tmr_pend[k]) begin
        if (k < MASK_W) res.pending[k] = 1'b1;
        if (tmr_inten[k]) res.irq = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. Reset is also released here so
  // that it never races the sampling process.
  // ---------------------------------------------------------------------------
  int  rst_count = 0;
  int  in_gap    = 0;
  bit  in_taken  = 1'b0;   // set on the rising edge that completed an input transfer
  timer_op_t next_op;

  always @(negedge clk) begin
    if (rst_count < RESET_CYCLES) begin
      rst_count = rst_count + 1;
      if (rst_count == RESET_CYCLES) rst_n <= 1'b1;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (op_backlog.size() > 0) begin
        next_op = op_backlog.pop_front();
        in_action         <= next_op.action;
        in_channel        <= next_op.channel;
        in_register_index <= next_op.reg_idx;
        in_write_data     <= next_op.data;
        in_valid          <= 1'b1;
        // occasional burst of idle cycles before the following item
        if (op_backlog.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, also in bursts, none near the end
  int out_stall = 0;

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (op_backlog.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
        out_stall = $urandom_range(1, 4);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled on the rising edge. A result cannot share an
  // edge with its own input transfer, so the two checks are independent.
  // ---------------------------------------------------------------------------
  timer_op_t     seen_op;
  timer_result_t predicted, observed;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      seen_op = '{in_action, in_channel, in_register_index, in_write_data};
      apply_timer_op(seen_op, predicted);
      due_results.push_back(predicted);
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result transfer", out_read_data, '0);
      end else begin
        observed = due_results.pop_front();
        if (out_read_data !== observed.read_data)
          report_mismatch("read_data", out_read_data, observed.read_data);
        if (out_irq !== observed.irq)
          report_mismatch("irq", DATA_W'(out_irq), DATA_W'(observed.irq));
        if (out_pending_mask !== observed.pending)
          report_mismatch("pending_mask", DATA_W'(out_pending_mask),
                          DATA_W'(observed.pending));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_op(input logic [ACTION_W-1:0] action, input logic [CHAN_W-1:0] ch,
                          input logic [REG_IDX_W-1:0] ri, input logic [DATA_W-1:0] data);
    op_backlog.push_back('{action, ch, ri, data});
  endtask

  function automatic logic [DATA_W-1:0] pick_interval();
    logic [DATA_W-1:0] v;
    // mostly short intervals so channels expire often; now and then anything at all
    if ($urandom_range(0, 9) == 0) v = $urandom;
    else v = $urandom_range(0, 12);
    v[LOAD_BIT] = ($urandom_range(0, 3) != 0);
    return v;
  endfunction

  int burst;

  initial begin
    // Directed opening: reset values, one-shot expiry and clear, widest interval,
    // load with zero, repeat with zero reload, ignored writes, unused action
    queue_op(ACT_READ,  2'd0, REG_INTERVAL, '0);
    queue_op(ACT_READ,  2'd0, REG_COUNT,    '0);
    queue_op(ACT_READ,  2'd0, REG_CONTROL,  '0);
    queue_op(ACT_READ,  2'd0, REG_STATUS,   '0);
    queue_op(ACT_WRITE, 2'd0, REG_CONTROL,  (1 << CTL_INTEN_BIT) | (1 << CTL_ONESHOT_BIT));
    queue_op(ACT_WRITE, 2'd0, REG_INTERVAL, (32'd1 << LOAD_BIT) | 32'd2);
    queue_op(ACT_TICK,  2'd0, 2'd0,         '0);
    queue_op(ACT_TICK,  2'd3, 2'd3,         '1);
    queue_op(ACT_READ,  2'd0, REG_STATUS,   '0);
    queue_op(ACT_WRITE, 2'd0, REG_STATUS,   32'd1 << STS_PENDING_BIT);
    queue_op(ACT_WRITE, 2'd1, REG_INTERVAL, '1);
    queue_op(ACT_TICK,  2'd0, 2'd0,         '0);
    queue_op(ACT_READ,  2'd1, REG_COUNT,    '0);
    queue_op(ACT_WRITE, 2'd1, REG_INTERVAL, 32'd1 << LOAD_BIT);
    queue_op(ACT_WRITE, 2'd2, REG_CONTROL,  32'd1 << CTL_INTEN_BIT);
    queue_op(ACT_WRITE, 2'd2, REG_INTERVAL, (32'd1 << LOAD_BIT) | 32'd1);
    queue_op(ACT_WRITE, 2'd2, REG_INTERVAL, '0);
    queue_op(ACT_TICK,  2'd0, 2'd0,         '0);
    queue_op(ACT_READ,  2'd2, REG_STATUS,   '0);
    queue_op(ACT_WRITE, 2'd3, REG_INTERVAL, 32'd3);
    queue_op(ACT_WRITE, 2'd3, REG_COUNT,    '1);
    queue_op(ACT_READ,  2'd3, REG_COUNT,    '0);
    queue_op(ACT_WRITE, 2'd2, REG_STATUS,   ~(32'd1 << STS_PENDING_BIT));
    queue_op(ACT_NOP,   2'd3, 2'd3,         '1);
    queue_op(ACT_WRITE, 2'd3, REG_CONTROL,  '1);
    queue_op(ACT_READ,  2'd3, REG_CONTROL,  '0);

    // Random part: tick-heavy so that channels expire, reload and stop often
    while (op_backlog.size() < TOTAL_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          burst = $urandom_range(1, 6);
          repeat (burst)
            queue_op(ACT_TICK, CHAN_W'($urandom), REG_IDX_W'($urandom), $urandom);
        end
        9, 10, 11:  queue_op(ACT_WRITE, CHAN_W'($urandom), REG_INTERVAL, pick_interval());
        12, 13:     queue_op(ACT_WRITE, CHAN_W'($urandom), REG_CONTROL, $urandom);
        14, 15:     queue_op(ACT_WRITE, CHAN_W'($urandom), REG_STATUS, $urandom);
        16, 17, 18: queue_op(ACT_READ, CHAN_W'($urandom), REG_IDX_W'($urandom), $urandom);
        default: begin
          // odd ones: no-op action or a write to the read-only count
          if ($urandom_range(0, 1))
            queue_op(ACT_NOP, CHAN_W'($urandom), REG_IDX_W'($urandom), $urandom);
          else queue_op(ACT_WRITE, CHAN_W'($urandom), REG_COUNT, $urandom);
        end
      endcase
    end

    // Wait for every item to be offered and every result to come back
    while (!rst_n || op_backlog.size() > 0 || in_valid || due_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** multi_channel_down_timer_unit: PASSED **");
    end else begin
      $display("** multi_channel_down_timer_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", due_results.size());
    $display("** multi_channel_down_timer_unit: FAILED **");
    $finish;
  end

endmodule
